>>> sv/isl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isl_pkg
// Shared sizes, command codes and cell controls for the indexed sequence list.
// ----------------------------------------------------------------------------
package isl_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_WIDTH = 32;

    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int S_DATA_W = ((POS_W + DATA_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((DATA_W + POS_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_LOAD_NEW   = 2'd1;
    localparam logic [1:0] CELL_TAKE_LOWER = 2'd2;
    localparam logic [1:0] CELL_TAKE_UPPER = 2'd3;

    typedef struct packed {
        logic [1:0] op;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> sv/isl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isl_cell
// One list slot: holds a word, loads a new one or takes a neighbor's word.
// ----------------------------------------------------------------------------
module isl_cell (
    input  wire                                   clk,
    input  wire isl_pkg::cell_ctrl_t              ctrl,
    input  wire  [isl_pkg::WORD_WIDTH-1:0]        new_word,
    input  wire  [isl_pkg::WORD_WIDTH-1:0]        lower_word,
    input  wire  [isl_pkg::WORD_WIDTH-1:0]        upper_word,
    output logic [isl_pkg::WORD_WIDTH-1:0]        word
);

    logic [isl_pkg::WORD_WIDTH-1:0] word_reg;
    logic [isl_pkg::WORD_WIDTH-1:0] word_next;

    always_comb
    begin
        unique case (ctrl.op)
            isl_pkg::CELL_LOAD_NEW:   word_next = new_word;
            isl_pkg::CELL_TAKE_LOWER: word_next = lower_word;
            isl_pkg::CELL_TAKE_UPPER: word_next = upper_word;
            default:                  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule
`default_nettype wire

>>> sv/indexed_sequence_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_sequence_list
// Ordered list of up to CAPACITY words, edited by position.
//
// Requests enter on the s_ channel (command in s_tuser, position and word in
// s_tdata); each gives exactly one result beat on the m_ channel with the
// read word and the element count in m_tdata and the fault flag in m_tuser.
// Insert moves every element at or above the position up one slot, remove
// moves every element above it down one slot, and read selects one slot.
// A refused request (position out of range, insert into a full list or an
// unknown command) sets fault and leaves the list as it was.
// The result beat follows in the cycle after the accepted request beat; one
// request is taken per cycle while results are taken, since the whole row of
// cells shifts in the same clock edge. The result sits in an output register:
// while the receiver stalls, the held result blocks the next request, and a
// request is taken in the same cycle that the held result is taken.
// Reset empties the list (count zero) and drops any pending result; the
// slot contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_sequence_list (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [isl_pkg::S_DATA_W-1:0]        s_tdata,  // position, data_word, zero fill
    input  wire  [isl_pkg::CMD_W-1:0]           s_tuser,  // command
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [isl_pkg::M_DATA_W-1:0]        m_tdata,  // read_word, count, zero fill
    output logic                                m_tuser   // fault
);

    localparam int CAP = isl_pkg::CAPACITY;
    localparam int WW  = isl_pkg::WORD_WIDTH;

    logic [isl_pkg::POS_W-1:0]  position;
    logic [isl_pkg::DATA_W-1:0] data_word;
    logic [WW-1:0]              new_word;
    logic [isl_pkg::CMP_W-1:0]  pos_ext;
    logic [isl_pkg::CMP_W-1:0]  cnt_ext;
    logic                       accept;
    logic                       ins_ok;
    logic                       rem_ok;
    logic                       rd_ok;
    logic                       fault;

    logic [isl_pkg::CNT_W-1:0]  count_reg;
    logic [isl_pkg::CNT_W-1:0]  count_next;
    logic                       m_valid_reg;
    logic [isl_pkg::DATA_W-1:0] read_word_reg;
    logic [isl_pkg::DATA_W-1:0] read_word_next;
    logic [isl_pkg::POS_W-1:0]  count_out_reg;
    logic                       fault_reg;

    logic [WW-1:0]              cell_word [CAP];

    assign position  = s_tdata[isl_pkg::POS_W-1:0];
    assign data_word = s_tdata[isl_pkg::POS_W +: isl_pkg::DATA_W];

    always_comb
    begin
        new_word = '0;
        for (int b = 0; b < WW; b++)
        begin
            if (b < isl_pkg::DATA_W)
            begin
                new_word[b] = data_word[b];
            end
        end
    end

    assign pos_ext  = isl_pkg::CMP_W'(position);
    assign cnt_ext  = isl_pkg::CMP_W'(count_reg);
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign ins_ok = (s_tuser == isl_pkg::CMD_INSERT) && (pos_ext <= cnt_ext)
                    && (cnt_ext != isl_pkg::CMP_W'(CAP));
    assign rem_ok = (s_tuser == isl_pkg::CMD_REMOVE) && (pos_ext < cnt_ext);
    assign rd_ok  = (s_tuser == isl_pkg::CMD_READ) && (pos_ext < cnt_ext);
    assign fault  = !(ins_ok || rem_ok || rd_ok);

    // Per-cell shift decisions
    genvar gi;
    generate
        for (gi = 0; gi < CAP; gi++)
        begin : g_cell
            logic [WW-1:0]       lower_w;
            logic [WW-1:0]       upper_w;
            isl_pkg::cell_ctrl_t ctrl_c;

            always_comb
            begin
                ctrl_c.op = isl_pkg::CELL_HOLD;
                if (accept && ins_ok)
                begin
                    if (pos_ext == isl_pkg::CMP_W'(gi))
                    begin
                        ctrl_c.op = isl_pkg::CELL_LOAD_NEW;
                    end
                    else if (pos_ext < isl_pkg::CMP_W'(gi))
                    begin
                        ctrl_c.op = isl_pkg::CELL_TAKE_LOWER;
                    end
                end
                else if (accept && rem_ok && (pos_ext <= isl_pkg::CMP_W'(gi)))
                begin
                    ctrl_c.op = isl_pkg::CELL_TAKE_UPPER;
                end
            end

            if (gi == 0)
            begin : g_first
                assign lower_w = '0;
            end
            else
            begin : g_mid_lo
                assign lower_w = cell_word[gi-1];
            end

            if (gi == CAP - 1)
            begin : g_last
                assign upper_w = '0;
            end
            else
            begin : g_mid_hi
                assign upper_w = cell_word[gi+1];
            end

            isl_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl_c),
                .new_word   (new_word),
                .lower_word (lower_w),
                .upper_word (upper_w),
                .word       (cell_word[gi])
            );
        end
    endgenerate

    always_comb
    begin
        read_word_next = '0;
        if (rd_ok)
        begin
            read_word_next = isl_pkg::DATA_W'(cell_word[position[isl_pkg::IDX_W-1:0]]);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rem_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_word_reg <= read_word_next;
            count_out_reg <= isl_pkg::POS_W'(isl_pkg::CMP_W'(count_next));
            fault_reg     <= fault;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = isl_pkg::M_DATA_W'({count_out_reg, read_word_reg});
    assign m_tuser  = fault_reg;

endmodule
`default_nettype wire
